>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FRWA_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FRWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/frwa_pkg.sv
// shared types and constants of the flow rate window average block
// depends on nothing; used by the interfaces, the divider and the top level
package frwa_pkg;

    localparam int WINDOW_DEF = 5;
    localparam int WINDOW_MAX = 16;

    localparam int INTERVAL_W = 16;
    localparam int THR_W      = 16;
    localparam int VOL_W      = 12;
    localparam int RATE_W     = 22;
    localparam int SUM_W      = 26;
    localparam int FILL_W     = 5;
    localparam int CNT_W      = 5;   // divider iteration count, up to SUM_W
    localparam int DVS_W      = 16;  // divider divisor width
    localparam int PAD_W      = SUM_W - RATE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd500;
    localparam logic [VOL_W-1:0] VOL_RESET = 12'd600;
    localparam logic [RATE_W-1:0] MS_PER_S = 22'd1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NO_FLOW_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_PER_PULSE = 2'd1;

    localparam logic [RATE_W-1:0] RATE_MAX = 22'd4095000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_UPD,
        S_AVG,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] bits;      // number of quotient bits to produce
        logic [SUM_W-1:0] dividend;  // left aligned
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/frwa_if.sv
// handshake channels of the flow rate window average block
// depends on frwa_pkg for payload widths
interface frwa_in_if;
    logic                               valid;
    logic                               ready;
    logic [frwa_pkg::INTERVAL_W-1:0]    pulse_interval_ms;
    modport source(output valid, output pulse_interval_ms, input ready);
    modport sink(input valid, input pulse_interval_ms, output ready);
endinterface

interface frwa_out_if;
    logic                           valid;
    logic                           ready;
    logic [frwa_pkg::RATE_W-1:0]    average_flow_ul_per_s;
    logic [frwa_pkg::FILL_W-1:0]    entries_held;
    modport source(output valid, output average_flow_ul_per_s, output entries_held,
                   input ready);
    modport sink(input valid, input average_flow_ul_per_s, input entries_held,
                 output ready);
endinterface

interface frwa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [frwa_pkg::CFG_IDX_W-1:0]     index;
    logic [frwa_pkg::CFG_DATA_W-1:0]    data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/frwa_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on frwa_pkg for the request and response structs
module frwa_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frwa_pkg::t_div_req i_req,
    output frwa_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [frwa_pkg::CNT_W-1:0]     r_cnt;
    logic [frwa_pkg::SUM_W-1:0]     r_dvd;
    logic [frwa_pkg::SUM_W-1:0]     r_quo;
    logic [frwa_pkg::DVS_W-1:0]     r_rem;
    logic [frwa_pkg::DVS_W-1:0]     r_dvs;

    logic [frwa_pkg::DVS_W:0]       trial;
    logic [frwa_pkg::DVS_W:0]       diff;
    logic                           q_bit;

    always_comb begin
        trial = {r_rem, r_dvd[frwa_pkg::SUM_W-1]};
        diff  = trial - {1'b0, r_dvs};
        q_bit = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.bits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - frwa_pkg::CNT_W'(1);
                if (r_cnt == frwa_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[frwa_pkg::SUM_W-2:0], 1'b0};
            r_rem <= q_bit ? diff[frwa_pkg::DVS_W-1:0] : trial[frwa_pkg::DVS_W-1:0];
            r_quo <= {r_quo[frwa_pkg::SUM_W-2:0], q_bit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> hw/rtl/flow_rate_window_average_top.sv
// each item takes two passes through the shared divider, the rate division and then
// the window average; a new item is accepted only in the idle state, after the last
// result is loaded, also while that result still waits in the output register
// reset (synchronous, active low) restores threshold 500 ms and 600 ul per pulse
// and empties the window; the rate memory itself is not cleared
module flow_rate_window_average_top #(
    parameter int WINDOW = frwa_pkg::WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    frwa_in_if.sink           i_in,
    frwa_cfg_if.sink          i_cfg,
    frwa_out_if.source        o_out
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    frwa_pkg::t_state                   r_state;
    frwa_pkg::t_state                   n_state;

    logic [frwa_pkg::THR_W-1:0]         r_thr;
    logic [frwa_pkg::VOL_W-1:0]         r_vol;

    logic [frwa_pkg::FILL_W-1:0]        r_fill;
    logic [frwa_pkg::FILL_W-1:0]        n_fill;
    logic [SLOT_W-1:0]                  r_oldest;
    logic [SLOT_W-1:0]                  n_oldest;
    logic [frwa_pkg::SUM_W-1:0]         r_sum;
    logic [frwa_pkg::SUM_W-1:0]         n_sum;
    logic                               r_full;
    logic [frwa_pkg::RATE_W-1:0]        r_rate;
    logic [frwa_pkg::RATE_W-1:0]        r_rd;
    logic [SLOT_W-1:0]                  wslot;
    logic                               mem_we;

    logic [frwa_pkg::RATE_W-1:0]        r_mem [WINDOW];

    logic                               r_out_valid;
    logic [frwa_pkg::RATE_W-1:0]        r_out_avg;
    logic [frwa_pkg::FILL_W-1:0]        r_out_cnt;
    logic                               out_load;

    logic                               in_acc;
    logic                               over;
    logic [frwa_pkg::RATE_W-1:0]        prod;
    logic [frwa_pkg::DVS_W-1:0]         ivl_dvs;

    frwa_pkg::t_div_req                 div_req;
    frwa_pkg::t_div_rsp                 div_rsp;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == frwa_pkg::S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= frwa_pkg::THR_RESET;
            r_vol <= frwa_pkg::VOL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                frwa_pkg::REG_NO_FLOW_THR:
                    r_thr <= i_cfg.data[frwa_pkg::THR_W-1:0];
                frwa_pkg::REG_VOL_PER_PULSE:
                    r_vol <= i_cfg.data[frwa_pkg::VOL_W-1:0];
                default: ;
            endcase
        end
    end

    // instantaneous rate request: volume * 1000 / interval, zero above threshold
    always_comb begin
        over    = (i_in.pulse_interval_ms > r_thr);
        prod    = frwa_pkg::RATE_W'(r_vol) * frwa_pkg::MS_PER_S;
        ivl_dvs = (i_in.pulse_interval_ms == '0) ? frwa_pkg::DVS_W'(1)
                                                 : i_in.pulse_interval_ms;
    end

    always_comb begin
        n_sum    = r_full ? (r_sum - frwa_pkg::SUM_W'(r_rd) + frwa_pkg::SUM_W'(r_rate))
                          : (r_sum + frwa_pkg::SUM_W'(r_rate));
        wslot    = r_full ? r_oldest : r_fill[SLOT_W-1:0];
        n_fill   = r_full ? r_fill : (r_fill + frwa_pkg::FILL_W'(1));
        n_oldest = r_oldest;
        if (r_full) begin
            n_oldest = (r_oldest == SLOT_W'(WINDOW - 1)) ? '0
                                                         : (r_oldest + SLOT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= frwa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        mem_we   = 1'b0;
        out_load = 1'b0;
        div_req  = '0;
        case (r_state)
            frwa_pkg::S_IDLE: begin
                if (in_acc) begin
                    div_req.start    = 1'b1;
                    div_req.bits     = frwa_pkg::CNT_W'(frwa_pkg::RATE_W);
                    div_req.dividend = over ? '0 : {prod, {frwa_pkg::PAD_W{1'b0}}};
                    div_req.divisor  = ivl_dvs;
                    n_state          = frwa_pkg::S_RATE;
                end
            end
            frwa_pkg::S_RATE: begin
                if (div_rsp.done) begin
                    n_state = frwa_pkg::S_UPD;
                end
            end
            frwa_pkg::S_UPD: begin
                mem_we           = 1'b1;
                div_req.start    = 1'b1;
                div_req.bits     = frwa_pkg::CNT_W'(frwa_pkg::SUM_W);
                div_req.dividend = n_sum;
                div_req.divisor  = frwa_pkg::DVS_W'(n_fill);
                n_state          = frwa_pkg::S_AVG;
            end
            frwa_pkg::S_AVG: begin
                if (div_rsp.done) begin
                    n_state = frwa_pkg::S_OUT;
                end
            end
            frwa_pkg::S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = frwa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frwa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_oldest <= '0;
            r_sum    <= '0;
            r_full   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_full <= (r_fill == frwa_pkg::FILL_W'(WINDOW));
            end
            if (mem_we) begin
                r_fill   <= n_fill;
                r_oldest <= n_oldest;
                r_sum    <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == frwa_pkg::S_RATE && div_rsp.done) begin
            r_rate <= div_rsp.quotient[frwa_pkg::RATE_W-1:0];
        end
    end

    // the eviction read on accept always follows the previous item's write-back
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wslot] <= r_rate;
        end
        if (in_acc) begin
            r_rd <= r_mem[r_oldest];
        end
    end

    frwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // divider quotient holds until the next start, so it is read here
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg <= div_rsp.quotient[frwa_pkg::RATE_W-1:0];
            r_out_cnt <= r_fill;
        end
    end

    assign o_out.valid                 = r_out_valid;
    assign o_out.average_flow_ul_per_s = r_out_avg;
    assign o_out.entries_held          = r_out_cnt;

endmodule

>>> hw/rtl/frwa_checker.sv
// port level checks of the flow rate window average block, bound to the top level
// depends on assert_macros.svh and frwa_pkg
`include "assert_macros.svh"

module frwa_checker #(
    parameter int WINDOW = frwa_pkg::WINDOW_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [frwa_pkg::RATE_W-1:0]      i_out_avg,
    input logic [frwa_pkg::FILL_W-1:0]      i_out_cnt
);

    `FRWA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_avg) && $stable(i_out_cnt), "result beat changed while stalled")

    `FRWA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input taken while an item is in work")

    `FRWA_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, !i_out_valid || (i_out_cnt >= frwa_pkg::FILL_W'(1) && i_out_cnt <= frwa_pkg::FILL_W'(WINDOW)), "entries held out of range")

    `FRWA_ASSERT_ALWAYS(a_avg_range, i_clk, i_rst_n, !i_out_valid || (i_out_avg <= frwa_pkg::RATE_MAX), "average above largest rate")

endmodule

bind flow_rate_window_average_top frwa_checker #(
    .WINDOW (WINDOW)
) u_frwa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_avg   (o_out.average_flow_ul_per_s),
    .i_out_cnt   (o_out.entries_held)
);

>>> tb/flow_rate_window_average_top_tb.sv
// testbench for the flow rate window average block: directed table, then random
// pulse intervals under changing register settings; depends on frwa_pkg and the frwa_*_if
// interfaces, checks every average against the table's value or a predictor of the rate window
module flow_rate_window_average_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WIN            = frwa_pkg::WINDOW_DEF;
    localparam int          CLK_PERIOD     = 4;
    localparam int          RST_CYCLES     = 5;
    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int          TAIL_CYCLES    = 110;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          SEGS_PER_PHASE = 6;
    localparam int          ITEMS_PER_SEG  = 88;
    localparam int          MAX_REPORTS    = 10;

    // indexes past the register list, writes there must be dropped
    localparam logic [frwa_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [frwa_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef enum logic {ST_ITEM, ST_REG} t_step_kind;

    typedef struct packed {
        t_step_kind                          kind;
        logic [frwa_pkg::CFG_IDX_W-1:0]      idx;
        logic [frwa_pkg::CFG_DATA_W-1:0]     val;
        logic                                typed;
        logic [frwa_pkg::RATE_W-1:0]         avg;
        logic [frwa_pkg::FILL_W-1:0]         held;
    } t_step;

    typedef struct packed {
        logic [frwa_pkg::RATE_W-1:0] avg;
        logic [frwa_pkg::FILL_W-1:0] held;
    } t_flow_avg;

    localparam int PLAN_LEN = 28;

    // defaults after reset: 500 ms threshold, 600 ul per pulse
    t_step warmup_plan [PLAN_LEN] = '{
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd501,   1'b1, 22'd0,      5'd1},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd500,   1'b1, 22'd600,    5'd2},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd1,     1'b1, 22'd200400, 5'd3},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd0,     1'b1, 22'd300300, 5'd4},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd65535, 1'b1, 22'd240240, 5'd5},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd7,     1'b0, 22'd0,      5'd0},
        '{ST_REG,  frwa_pkg::REG_NO_FLOW_THR,   16'hFFFF,  1'b0, 22'd0,      5'd0},
        '{ST_REG,  frwa_pkg::REG_VOL_PER_PULSE, 16'd4095,  1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd0,     1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd65535, 1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd1,     1'b0, 22'd0,      5'd0},
        '{ST_REG,  REG_SPARE_LO,                16'h0001,  1'b0, 22'd0,      5'd0},
        '{ST_REG,  REG_SPARE_HI,                16'hF000,  1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd2,     1'b0, 22'd0,      5'd0},
        '{ST_REG,  frwa_pkg::REG_VOL_PER_PULSE, 16'hF000,  1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd1,     1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd300,   1'b0, 22'd0,      5'd0},
        '{ST_REG,  frwa_pkg::REG_NO_FLOW_THR,   16'd0,     1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd0,     1'b0, 22'd0,      5'd0},
        '{ST_REG,  frwa_pkg::REG_VOL_PER_PULSE, 16'd1,     1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd0,     1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd1,     1'b0, 22'd0,      5'd0},
        '{ST_REG,  frwa_pkg::REG_NO_FLOW_THR,   16'd500,   1'b0, 22'd0,      5'd0},
        '{ST_REG,  frwa_pkg::REG_VOL_PER_PULSE, 16'd600,   1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd3,     1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd65534, 1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd500,   1'b0, 22'd0,      5'd0},
        '{ST_ITEM, frwa_pkg::REG_NO_FLOW_THR,   16'd501,   1'b0, 22'd0,      5'd0}
    };

    logic i_clk;
    logic i_rst_n;

    frwa_in_if  in_ch();
    frwa_cfg_if cfg_ch();
    frwa_out_if out_ch();

    flow_rate_window_average_top #(
        .WINDOW(WIN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // predictor state: register copies and the rate ring
    logic [frwa_pkg::THR_W-1:0]  cur_thr;
    logic [frwa_pkg::VOL_W-1:0]  cur_vol;
    logic [frwa_pkg::RATE_W-1:0] rate_ring [WIN];
    logic [frwa_pkg::SUM_W-1:0]  ring_sum;
    int unsigned                 ring_fill;
    int unsigned                 ring_oldest;

    t_flow_avg   avg_expect_q [$];
    t_flow_avg   oldest_avg;

    int unsigned mismatches;
    int unsigned intervals_sent;
    int unsigned averages_seen;
    int unsigned reg_writes;
    int unsigned zero_rates;
    int unsigned cycle_cnt;
    int          src_idle_pct = 17;
    int          snk_idle_pct = 50;
    logic        rx_hold;
    event        rx_hold_ev;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [frwa_pkg::RATE_W-1:0] instant_flow(
        input logic [frwa_pkg::INTERVAL_W-1:0] iv);
        logic [31:0] dvs;
        logic [31:0] prod;
        if (iv > cur_thr) return '0;
        // a zero interval divides as one millisecond
        dvs  = (iv == '0) ? 32'd1 : {16'd0, iv};
        prod = 32'(cur_vol) * 32'd1000;
        return frwa_pkg::RATE_W'(prod / dvs);
    endfunction

    task automatic track_flow(input logic [frwa_pkg::INTERVAL_W-1:0] iv,
                              output t_flow_avg res);
        logic [frwa_pkg::RATE_W-1:0] rate;
        rate = instant_flow(iv);
        if (rate == '0) zero_rates++;
        if (ring_fill < WIN) begin
            rate_ring[ring_fill] = rate;
            ring_fill++;
            ring_sum = ring_sum + rate;
        end else begin
            // full ring: the oldest rate drops out of the sum
            ring_sum = ring_sum - rate_ring[ring_oldest] + rate;
            rate_ring[ring_oldest] = rate;
            ring_oldest = (ring_oldest + 1 == WIN) ? 0 : ring_oldest + 1;
        end
        res.avg  = frwa_pkg::RATE_W'(ring_sum / ring_fill);
        res.held = frwa_pkg::FILL_W'(ring_fill);
    endtask

    task automatic note_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("average beat %0d: %s expected %0d, got %0d",
                     averages_seen, what, want, got);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (avg_expect_q.size() != 0);
    endtask

    task automatic write_reg(input logic [frwa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [frwa_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == frwa_pkg::REG_NO_FLOW_THR)
            cur_thr = val[frwa_pkg::THR_W-1:0];
        else if (idx == frwa_pkg::REG_VOL_PER_PULSE)
            cur_vol = val[frwa_pkg::VOL_W-1:0];
        reg_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_interval(input logic [frwa_pkg::INTERVAL_W-1:0] iv,
                                 input logic typed,
                                 input logic [frwa_pkg::RATE_W-1:0] t_avg,
                                 input logic [frwa_pkg::FILL_W-1:0] t_held);
        int        gap;
        t_flow_avg res;
        // now and then a long gap so the next beat lands late in the block's work
        gap = (src_idle_pct != 0 && $urandom_range(49) == 0) ? $urandom_range(2, 70) : 0;
        while (gap > 0 || $urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
            if (gap > 0) gap--;
        end
        in_ch.valid             <= 1'b1;
        in_ch.pulse_interval_ms <= iv;
        do @(posedge i_clk); while (!in_ch.ready);
        track_flow(iv, res);
        if (typed) begin
            res.avg  = t_avg;
            res.held = t_held;
        end
        avg_expect_q.push_back(res);
        intervals_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [frwa_pkg::INTERVAL_W-1:0] pick_interval();
        int unsigned sel;
        int unsigned top;
        sel = $urandom_range(99);
        top = (cur_thr > 50) ? 50 : cur_thr;
        if (sel < 8) begin
            case ($urandom_range(4))
                0: return '0;
                1: return 16'd1;
                2: return cur_thr;
                3: return cur_thr + 16'd1;
                default: return '1;
            endcase
        end else if (sel < 35) begin
            return (top == 0) ? '0 : frwa_pkg::INTERVAL_W'($urandom_range(1, top));
        end else if (sel < 65) begin
            return (cur_thr == 0) ? '0 : frwa_pkg::INTERVAL_W'($urandom_range(1, cur_thr));
        end else if (sel < 82) begin
            return (cur_thr == '1) ? '1
                                   : frwa_pkg::INTERVAL_W'($urandom_range(cur_thr + 1, 65535));
        end
        return frwa_pkg::INTERVAL_W'($urandom_range(65535));
    endfunction

    task automatic shuffle_registers();
        logic [frwa_pkg::CFG_DATA_W-1:0] thr_val;
        logic [frwa_pkg::CFG_DATA_W-1:0] vol_val;
        case ($urandom_range(3))
            0: thr_val = '0;
            1: thr_val = '1;
            2: thr_val = frwa_pkg::CFG_DATA_W'($urandom_range(65535));
            default: thr_val = frwa_pkg::CFG_DATA_W'($urandom_range(100, 2000));
        endcase
        case ($urandom_range(5))
            0: vol_val = {4'($urandom_range(15)), 12'd0};
            1: vol_val = {4'($urandom_range(15)), 12'hFFF};
            default: vol_val = frwa_pkg::CFG_DATA_W'($urandom_range(65535));
        endcase
        write_reg(frwa_pkg::REG_NO_FLOW_THR, thr_val);
        write_reg(frwa_pkg::REG_VOL_PER_PULSE, vol_val);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                      frwa_pkg::CFG_DATA_W'($urandom_range(65535)));
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (rx_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always begin
        @(rx_hold_ev);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            averages_seen++;
            if (avg_expect_q.size() == 0) begin
                note_mismatch("unexpected beat, average", 0, out_ch.average_flow_ul_per_s);
            end else begin
                oldest_avg = avg_expect_q.pop_front();
                if (out_ch.average_flow_ul_per_s !== oldest_avg.avg)
                    note_mismatch("average_flow_ul_per_s", oldest_avg.avg,
                                  out_ch.average_flow_ul_per_s);
                if (out_ch.entries_held !== oldest_avg.held)
                    note_mismatch("entries_held", oldest_avg.held, out_ch.entries_held);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d averages still owed",
                 cycle_cnt, avg_expect_q.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n                 = 1'b0;
        rx_hold                 = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.pulse_interval_ms = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        out_ch.ready            = 1'b0;
        cur_thr                 = frwa_pkg::THR_RESET;
        cur_vol                 = frwa_pkg::VOL_RESET;
        ring_sum                = '0;
        ring_fill               = 0;
        ring_oldest             = 0;
        mismatches              = 0;
        intervals_sent          = 0;
        averages_seen           = 0;
        reg_writes              = 0;
        zero_rates              = 0;
        for (int k = 0; k < WIN; k++) rate_ring[k] = '0;

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < PLAN_LEN; k++) begin
            if (warmup_plan[k].kind == ST_REG)
                write_reg(warmup_plan[k].idx, warmup_plan[k].val);
            else
                send_interval(warmup_plan[k].val, warmup_plan[k].typed,
                              warmup_plan[k].avg, warmup_plan[k].held);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 17;
                    snk_idle_pct = 50;
                end
                1: begin
                    src_idle_pct = 50;
                    snk_idle_pct = 17;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < SEGS_PER_PHASE; seg++) begin
                shuffle_registers();
                for (int k = 0; k < ITEMS_PER_SEG; k++) begin
                    // receiver stops taking beats while intervals keep coming
                    if (phase != 1 && seg == 2 && k == 10) -> rx_hold_ev;
                    // sender holds back until the pipeline is empty
                    if (seg == 3 && k == ITEMS_PER_SEG / 2) drain_results();
                    send_interval(pick_interval(), 1'b0, '0, '0);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d pulse intervals (%0d with zero rate) and %0d register writes",
                 intervals_sent, zero_rates, reg_writes);
        $display("%0d averages compared, %0d mismatches", averages_seen, mismatches);
        if (mismatches == 0 && avg_expect_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
